@@ rtl/core/cwrc_pkg.sv @@
package cwrc_pkg;

   localparam int unsigned WAKE_RETRIES_DEF       = 3;
   localparam int unsigned SUBSCRIBE_RETRIES_DEF  = 3;
   localparam int unsigned RPM_GONE_ABORT_MS_DEF  = 3000;
   localparam int unsigned RECORD_CONFIRM_MS_DEF  = 2000;
   localparam int unsigned PAIRING_TIMEOUT_MS_DEF = 60000;

   localparam int unsigned REQ_TDATA_W = 64;
   localparam int unsigned RSP_TDATA_W = 8;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned TRIES_W     = 4;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_SERIAL_PRESENT_INIT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RPM_ON_LEVEL        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RPM_OFF_LEVEL       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RPM_ON_HOLD_MS      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_START_MS     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_RECORD_MS      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CONNECT_WINDOW_MS   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SUBSCRIBE_WINDOW_MS = 3'd7;

   // action codes
   localparam logic [2:0] ACT_NONE     = 3'd0;
   localparam logic [2:0] ACT_WAKE     = 3'd1;
   localparam logic [2:0] ACT_STOP_ADV = 3'd2;
   localparam logic [2:0] ACT_DISC     = 3'd3;
   localparam logic [2:0] ACT_SHUTTER  = 3'd4;
   localparam logic [2:0] ACT_CONN_ADV = 3'd5;

   // observed record state codes
   localparam logic [1:0] SEEN_IDLE      = 2'd1;
   localparam logic [1:0] SEEN_RECORDING = 2'd2;

   // request kinds on tuser
   localparam logic REQ_STEP = 1'b0;
   localparam logic REQ_INIT = 1'b1;

   typedef enum logic [6:0] {
      MODE_UNPAIRED  = 7'b0000001,
      MODE_IDLE      = 7'b0000010,
      MODE_WAKING    = 7'b0000100,
      MODE_AWAIT     = 7'b0001000,
      MODE_RECORDING = 7'b0010000,
      MODE_WATCHING  = 7'b0100000,
      MODE_PAIRING   = 7'b1000000
   } mode_type;

   localparam logic [2:0] CODE_UNPAIRED  = 3'd0;
   localparam logic [2:0] CODE_IDLE      = 3'd1;
   localparam logic [2:0] CODE_WAKING    = 3'd2;
   localparam logic [2:0] CODE_AWAIT     = 3'd3;
   localparam logic [2:0] CODE_RECORDING = 3'd4;
   localparam logic [2:0] CODE_WATCHING  = 3'd5;
   localparam logic [2:0] CODE_PAIRING   = 3'd6;

   typedef struct packed {
      logic        serial_present_init;
      logic [15:0] rpm_on_level;
      logic [15:0] rpm_off_level;
      logic [31:0] rpm_on_hold_ms;
      logic [31:0] record_start_ms;
      logic [31:0] stop_record_ms;
      logic [31:0] connect_window_ms;
      logic [31:0] subscribe_window_ms;
   } cfg_type;

   typedef struct packed {
      logic        req_type;
      logic [31:0] now_ms;
      logic [15:0] rpm;
      logic        link_up;
      logic        camera_subscribed;
      logic [1:0]  record_seen;
      logic        session_end;
      logic        force_idle;
      logic        unpair_req;
      logic        pair_req;
      logic        serial_captured;
      logic        pair_cancel;
   } item_type;

   typedef struct packed {
      mode_type           mode;
      logic               paired;
      logic               believes_recording;
      mode_type           return_mode;
      logic [31:0]        rpm_on_start;
      logic [31:0]        rpm_gone_start;
      logic [31:0]        attempt_start;
      logic [TRIES_W-1:0] wake_tries;
      logic [TRIES_W-1:0] subscribe_tries;
      logic [31:0]        connect_start;
      logic [31:0]        arm_start;
      logic [31:0]        stop_start;
      logic [31:0]        idle_seen_start;
      logic               retry_spent;
      logic [31:0]        pair_start;
      logic               entry_owed;
   } state_type;

   function automatic logic [2:0] mode_code(input mode_type m);
      logic [2:0] c;
      case (m)
         MODE_UNPAIRED:  c = CODE_UNPAIRED;
         MODE_IDLE:      c = CODE_IDLE;
         MODE_WAKING:    c = CODE_WAKING;
         MODE_AWAIT:     c = CODE_AWAIT;
         MODE_RECORDING: c = CODE_RECORDING;
         MODE_WATCHING:  c = CODE_WATCHING;
         MODE_PAIRING:   c = CODE_PAIRING;
         default:        c = CODE_UNPAIRED;
      endcase
      return c;
   endfunction

   function automatic state_type state_cleared();
      state_type s;
      s                    = '0;
      s.mode               = MODE_UNPAIRED;
      s.return_mode        = MODE_UNPAIRED;
      return s;
   endfunction

endpackage

@@ rtl/core/cwrc_step.sv @@
module cwrc_step #(
   parameter int unsigned WAKE_RETRIES       = cwrc_pkg::WAKE_RETRIES_DEF,
   parameter int unsigned SUBSCRIBE_RETRIES  = cwrc_pkg::SUBSCRIBE_RETRIES_DEF,
   parameter int unsigned RPM_GONE_ABORT_MS  = cwrc_pkg::RPM_GONE_ABORT_MS_DEF,
   parameter int unsigned RECORD_CONFIRM_MS  = cwrc_pkg::RECORD_CONFIRM_MS_DEF,
   parameter int unsigned PAIRING_TIMEOUT_MS = cwrc_pkg::PAIRING_TIMEOUT_MS_DEF
) (
   input  cwrc_pkg::cfg_type   cfg,
   input  cwrc_pkg::item_type  item,
   input  cwrc_pkg::state_type cur,
   output cwrc_pkg::state_type nxt,
   output logic [2:0]          action
);

   localparam logic [cwrc_pkg::TRIES_W-1:0] WAKE_MAX = cwrc_pkg::TRIES_W'(WAKE_RETRIES);
   localparam logic [cwrc_pkg::TRIES_W-1:0] SUB_MAX  =
      cwrc_pkg::TRIES_W'(SUBSCRIBE_RETRIES);
   localparam logic [31:0] GONE_MS    = 32'(RPM_GONE_ABORT_MS);
   localparam logic [31:0] CONFIRM_MS = 32'(RECORD_CONFIRM_MS);
   localparam logic [31:0] PAIR_MS    = 32'(PAIRING_TIMEOUT_MS);

   // zero means a timer is not running, so a start at time zero is kept as one
   function automatic logic [31:0] stamp(input logic [31:0] now);
      return (now == 32'd0) ? 32'd1 : now;
   endfunction

   function automatic logic passed(input logic [31:0] now, input logic [31:0] since,
                                   input logic [31:0] span);
      logic [31:0] diff;
      diff = now - since;
      return diff >= span;
   endfunction

   function automatic cwrc_pkg::state_type clear_timers(input cwrc_pkg::state_type s);
      cwrc_pkg::state_type r;
      r                 = s;
      r.rpm_on_start    = '0;
      r.rpm_gone_start  = '0;
      r.attempt_start   = '0;
      r.wake_tries      = '0;
      r.subscribe_tries = '0;
      r.connect_start   = '0;
      r.arm_start       = '0;
      r.stop_start      = '0;
      r.idle_seen_start = '0;
      r.retry_spent     = 1'b0;
      r.pair_start      = '0;
      r.entry_owed      = 1'b0;
      return r;
   endfunction

   logic [31:0]                  now;
   logic [31:0]                  now_st;
   logic                         rpm_hi;
   logic                         rpm_lo;
   logic                         gone_abort;
   logic                         shut;
   logic                         done;
   logic [cwrc_pkg::TRIES_W-1:0] sub_tries_inc;

   assign now    = item.now_ms;
   assign now_st = stamp(item.now_ms);
   assign rpm_hi = item.rpm > cfg.rpm_on_level;
   assign rpm_lo = item.rpm < cfg.rpm_off_level;
   assign sub_tries_inc = cur.subscribe_tries + 1'b1;

   always_comb begin
      nxt        = cur;
      action     = cwrc_pkg::ACT_NONE;
      gone_abort = 1'b0;
      shut       = 1'b0;
      done       = 1'b0;
      if (item.req_type == cwrc_pkg::REQ_INIT) begin
         nxt        = cwrc_pkg::state_cleared();
         nxt.paired = cfg.serial_present_init;
         nxt.mode   = cfg.serial_present_init ? cwrc_pkg::MODE_IDLE : cwrc_pkg::MODE_UNPAIRED;
      end else if (item.force_idle) begin
         nxt                    = clear_timers(cur);
         nxt.believes_recording = 1'b0;
         nxt.mode = cur.paired ? cwrc_pkg::MODE_IDLE : cwrc_pkg::MODE_UNPAIRED;
         if (cur.mode == cwrc_pkg::MODE_WAKING || cur.mode == cwrc_pkg::MODE_PAIRING) begin
            action = cwrc_pkg::ACT_STOP_ADV;
         end
      end else if (item.unpair_req && (cur.mode == cwrc_pkg::MODE_UNPAIRED ||
                                       cur.mode == cwrc_pkg::MODE_IDLE)) begin
         nxt.mode   = cwrc_pkg::MODE_UNPAIRED;
         nxt.paired = 1'b0;
         action     = cwrc_pkg::ACT_DISC;
      end else begin
         if (item.pair_req && (cur.mode == cwrc_pkg::MODE_UNPAIRED ||
                               cur.mode == cwrc_pkg::MODE_IDLE)) begin
            nxt.return_mode = cur.mode;
            nxt.mode        = cwrc_pkg::MODE_PAIRING;
            nxt.pair_start  = now_st;
            nxt.entry_owed  = 1'b1;
         end
         if (item.serial_captured) begin
            nxt.paired = 1'b1;
            if (nxt.mode == cwrc_pkg::MODE_PAIRING) begin
               nxt                    = clear_timers(nxt);
               nxt.believes_recording = 1'b0;
               nxt.mode               = cwrc_pkg::MODE_IDLE;
               action                 = cwrc_pkg::ACT_DISC;
               done                   = 1'b1;
            end
         end
         if (!done) begin
            case (nxt.mode)
               cwrc_pkg::MODE_IDLE: begin
                  if (!rpm_hi) begin
                     nxt.rpm_on_start = '0;
                  end else if (nxt.rpm_on_start == 32'd0) begin
                     nxt.rpm_on_start = now_st;
                  end else if (passed(now, nxt.rpm_on_start, cfg.rpm_on_hold_ms)) begin
                     nxt.rpm_on_start = '0;
                     nxt.arm_start    = now_st;
                     if (item.link_up) begin
                        nxt.mode          = cwrc_pkg::MODE_AWAIT;
                        nxt.connect_start = now_st;
                        nxt.entry_owed    = 1'b0;
                     end else begin
                        nxt.mode           = cwrc_pkg::MODE_WAKING;
                        nxt.wake_tries     = cwrc_pkg::TRIES_W'(1);
                        nxt.attempt_start  = now_st;
                        nxt.rpm_gone_start = '0;
                        action             = cwrc_pkg::ACT_WAKE;
                     end
                  end
               end
               cwrc_pkg::MODE_WAKING: begin
                  if (item.link_up) begin
                     nxt.mode          = cwrc_pkg::MODE_AWAIT;
                     nxt.connect_start = now_st;
                     nxt.entry_owed    = 1'b0;
                  end else begin
                     if (rpm_hi) begin
                        if (nxt.arm_start == 32'd0) nxt.arm_start = now_st;
                     end else if (rpm_lo) begin
                        nxt.arm_start = '0;
                     end
                     if (rpm_lo) begin
                        if (nxt.rpm_gone_start == 32'd0) begin
                           nxt.rpm_gone_start = now_st;
                        end else if (passed(now, nxt.rpm_gone_start, GONE_MS)) begin
                           gone_abort = 1'b1;
                        end
                     end else begin
                        nxt.rpm_gone_start = '0;
                     end
                     if (gone_abort) begin
                        nxt      = clear_timers(nxt);
                        nxt.mode = cwrc_pkg::MODE_IDLE;
                        action   = cwrc_pkg::ACT_STOP_ADV;
                     end else if (passed(now, nxt.attempt_start, cfg.connect_window_ms)) begin
                        if (nxt.wake_tries < WAKE_MAX) begin
                           nxt.wake_tries     = nxt.wake_tries + 1'b1;
                           nxt.attempt_start  = now_st;
                           nxt.rpm_gone_start = '0;
                           action             = cwrc_pkg::ACT_WAKE;
                        end else begin
                           nxt      = clear_timers(nxt);
                           nxt.mode = cwrc_pkg::MODE_IDLE;
                           action   = cwrc_pkg::ACT_STOP_ADV;
                        end
                     end else if (item.session_end) begin
                        nxt      = clear_timers(nxt);
                        nxt.mode = cwrc_pkg::MODE_IDLE;
                        action   = cwrc_pkg::ACT_STOP_ADV;
                     end
                  end
               end
               cwrc_pkg::MODE_AWAIT: begin
                  if (rpm_hi) begin
                     if (nxt.arm_start == 32'd0) nxt.arm_start = now_st;
                  end else if (rpm_lo) begin
                     nxt.arm_start = '0;
                  end
                  if (!item.link_up) begin
                     nxt.mode           = cwrc_pkg::MODE_WAKING;
                     nxt.wake_tries     = cwrc_pkg::TRIES_W'(1);
                     nxt.attempt_start  = now_st;
                     nxt.rpm_gone_start = '0;
                     action             = cwrc_pkg::ACT_WAKE;
                  end else if (item.session_end) begin
                     if (nxt.believes_recording && item.camera_subscribed) begin
                        nxt.believes_recording = 1'b0;
                        action                 = cwrc_pkg::ACT_SHUTTER;
                     end
                     nxt.mode       = cwrc_pkg::MODE_WATCHING;
                     nxt.arm_start  = '0;
                     nxt.stop_start = '0;
                  end else if (!item.camera_subscribed &&
                               passed(now, nxt.connect_start, cfg.subscribe_window_ms)) begin
                     action = cwrc_pkg::ACT_DISC;
                     if (sub_tries_inc > SUB_MAX) begin
                        nxt      = clear_timers(nxt);
                        nxt.mode = cwrc_pkg::MODE_IDLE;
                     end else begin
                        nxt.subscribe_tries = sub_tries_inc;
                        nxt.mode            = cwrc_pkg::MODE_WAKING;
                        nxt.wake_tries      = cwrc_pkg::TRIES_W'(1);
                        nxt.attempt_start   = now_st;
                        nxt.rpm_gone_start  = '0;
                     end
                  end else if (item.camera_subscribed) begin
                     nxt.subscribe_tries = '0;
                     nxt.mode            = cwrc_pkg::MODE_WATCHING;
                     nxt.stop_start      = '0;
                  end
               end
               cwrc_pkg::MODE_RECORDING: begin
                  if (item.session_end) begin
                     if (nxt.believes_recording) begin
                        nxt.believes_recording = 1'b0;
                        action                 = cwrc_pkg::ACT_SHUTTER;
                     end
                     nxt.mode       = cwrc_pkg::MODE_WATCHING;
                     nxt.arm_start  = '0;
                     nxt.stop_start = '0;
                  end else if (!item.link_up) begin
                     nxt.mode           = cwrc_pkg::MODE_WAKING;
                     nxt.wake_tries     = cwrc_pkg::TRIES_W'(1);
                     nxt.attempt_start  = now_st;
                     nxt.rpm_gone_start = '0;
                     action             = cwrc_pkg::ACT_WAKE;
                  end else begin
                     // camera says idle while we think it records: one shutter retry
                     if (item.record_seen == cwrc_pkg::SEEN_RECORDING) begin
                        nxt.idle_seen_start = '0;
                        nxt.retry_spent     = 1'b0;
                     end else if (item.record_seen == cwrc_pkg::SEEN_IDLE &&
                                  nxt.believes_recording) begin
                        if (!nxt.retry_spent) begin
                           if (nxt.idle_seen_start == 32'd0) begin
                              nxt.idle_seen_start = now_st;
                           end else if (passed(now, nxt.idle_seen_start, CONFIRM_MS)) begin
                              nxt.idle_seen_start = '0;
                              nxt.retry_spent     = 1'b1;
                              shut                = 1'b1;
                           end
                        end
                     end else begin
                        nxt.idle_seen_start = '0;
                     end
                     if (shut) begin
                        action = cwrc_pkg::ACT_SHUTTER;
                     end else if (rpm_lo) begin
                        if (nxt.stop_start == 32'd0) begin
                           nxt.stop_start = now_st;
                        end else if (passed(now, nxt.stop_start, cfg.stop_record_ms)) begin
                           if (nxt.believes_recording) begin
                              nxt.believes_recording = 1'b0;
                              action                 = cwrc_pkg::ACT_SHUTTER;
                           end
                           nxt.mode       = cwrc_pkg::MODE_WATCHING;
                           nxt.arm_start  = '0;
                           nxt.stop_start = '0;
                        end
                     end else begin
                        nxt.stop_start = '0;
                     end
                  end
               end
               cwrc_pkg::MODE_WATCHING: begin
                  if (rpm_hi) begin
                     if (nxt.arm_start == 32'd0) nxt.arm_start = now_st;
                  end else if (rpm_lo) begin
                     nxt.arm_start = '0;
                  end
                  if (!item.link_up) begin
                     nxt                    = clear_timers(nxt);
                     nxt.believes_recording = 1'b0;
                     nxt.mode               = cwrc_pkg::MODE_IDLE;
                  end else if (!item.session_end && item.camera_subscribed &&
                               nxt.arm_start != 32'd0 &&
                               passed(now, nxt.arm_start, cfg.record_start_ms)) begin
                     if (item.record_seen == cwrc_pkg::SEEN_RECORDING) begin
                        shut = 1'b0;
                     end else if (item.record_seen == cwrc_pkg::SEEN_IDLE) begin
                        shut = 1'b1;
                     end else begin
                        shut = !nxt.believes_recording;
                     end
                     nxt.mode               = cwrc_pkg::MODE_RECORDING;
                     nxt.stop_start         = '0;
                     nxt.idle_seen_start    = '0;
                     nxt.retry_spent        = 1'b0;
                     nxt.subscribe_tries    = '0;
                     nxt.believes_recording = 1'b1;
                     action = shut ? cwrc_pkg::ACT_SHUTTER : cwrc_pkg::ACT_NONE;
                  end
               end
               cwrc_pkg::MODE_PAIRING: begin
                  if (nxt.entry_owed) begin
                     nxt.entry_owed = 1'b0;
                     action         = cwrc_pkg::ACT_CONN_ADV;
                  end else if (item.pair_cancel || passed(now, nxt.pair_start, PAIR_MS)) begin
                     nxt.mode         = nxt.return_mode;
                     nxt.rpm_on_start = '0;
                     action           = cwrc_pkg::ACT_STOP_ADV;
                  end
               end
               default: begin
                  action = cwrc_pkg::ACT_NONE;
               end
            endcase
         end
      end
   end

endmodule

@@ rtl/core/camera_wake_record_controller_unit.sv @@
// datapath: a taken request word goes into the input register, and one pass of step logic
// moves it into the result register once that register is empty or being drained
// throughput: one word per cycle while the result side takes words; the step logic runs once
// per word and its state update is committed in the same cycle the result register loads
// reset: synchronous, active high; clears mode to unpaired, all timers and flags,
// and loads the csr registers with their default values
module camera_wake_record_controller_unit #(
   parameter int unsigned WAKE_RETRIES       = cwrc_pkg::WAKE_RETRIES_DEF,
   parameter int unsigned SUBSCRIBE_RETRIES  = cwrc_pkg::SUBSCRIBE_RETRIES_DEF,
   parameter int unsigned RPM_GONE_ABORT_MS  = cwrc_pkg::RPM_GONE_ABORT_MS_DEF,
   parameter int unsigned RECORD_CONFIRM_MS  = cwrc_pkg::RECORD_CONFIRM_MS_DEF,
   parameter int unsigned PAIRING_TIMEOUT_MS = cwrc_pkg::PAIRING_TIMEOUT_MS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // now_ms[31:0], rpm[47:32], link_up[48], camera_subscribed[49],
   // record_seen[51:50], session_end[52], force_idle[53], unpair_req[54],
   // pair_req[55], serial_captured[56], pair_cancel[57], zero[63:58]
   input  logic [cwrc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_type[0]
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // action[2:0], mode_now[5:3], recording_belief[6], paired_flag[7]
   output logic [cwrc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                               csr_we,
   input  logic [cwrc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cwrc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   cwrc_pkg::cfg_type                 cfg_ff, cfg_in;
   cwrc_pkg::item_type                item_ff, item_in;
   logic                              in_vld_ff, in_vld_in;
   cwrc_pkg::state_type               state_ff, state_in, state_step;
   logic                              out_vld_ff, out_vld_in;
   logic [cwrc_pkg::RSP_TDATA_W-1:0]  out_data_ff, out_data_in;
   logic [2:0]                        step_action;
   logic                              step_go;
   logic                              req_take;

   // a word moves from the input register to the result register when the
   // result register is empty or being drained
   assign step_go    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || step_go;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      item_in                   = item_ff;
      in_vld_in                 = in_vld_ff;
      if (step_go) in_vld_in    = 1'b0;
      if (req_take) begin
         in_vld_in                 = 1'b1;
         item_in.req_type          = req_tuser;
         item_in.now_ms            = req_tdata[31:0];
         item_in.rpm               = req_tdata[47:32];
         item_in.link_up           = req_tdata[48];
         item_in.camera_subscribed = req_tdata[49];
         item_in.record_seen       = req_tdata[51:50];
         item_in.session_end       = req_tdata[52];
         item_in.force_idle        = req_tdata[53];
         item_in.unpair_req        = req_tdata[54];
         item_in.pair_req          = req_tdata[55];
         item_in.serial_captured   = req_tdata[56];
         item_in.pair_cancel       = req_tdata[57];
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            cwrc_pkg::CSR_SERIAL_PRESENT_INIT: cfg_in.serial_present_init = csr_wdata[0];
            cwrc_pkg::CSR_RPM_ON_LEVEL:        cfg_in.rpm_on_level        = csr_wdata[15:0];
            cwrc_pkg::CSR_RPM_OFF_LEVEL:       cfg_in.rpm_off_level       = csr_wdata[15:0];
            cwrc_pkg::CSR_RPM_ON_HOLD_MS:      cfg_in.rpm_on_hold_ms      = csr_wdata;
            cwrc_pkg::CSR_RECORD_START_MS:     cfg_in.record_start_ms     = csr_wdata;
            cwrc_pkg::CSR_STOP_RECORD_MS:      cfg_in.stop_record_ms      = csr_wdata;
            cwrc_pkg::CSR_CONNECT_WINDOW_MS:   cfg_in.connect_window_ms   = csr_wdata;
            cwrc_pkg::CSR_SUBSCRIBE_WINDOW_MS: cfg_in.subscribe_window_ms = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   cwrc_step #(
      .WAKE_RETRIES       (WAKE_RETRIES),
      .SUBSCRIBE_RETRIES  (SUBSCRIBE_RETRIES),
      .RPM_GONE_ABORT_MS  (RPM_GONE_ABORT_MS),
      .RECORD_CONFIRM_MS  (RECORD_CONFIRM_MS),
      .PAIRING_TIMEOUT_MS (PAIRING_TIMEOUT_MS)
   ) u_step (
      .cfg    (cfg_ff),
      .item   (item_ff),
      .cur    (state_ff),
      .nxt    (state_step),
      .action (step_action)
   );

   always_comb begin
      state_in    = state_ff;
      out_data_in = out_data_ff;
      out_vld_in  = out_vld_ff;
      if (out_vld_ff && rsp_tready) out_vld_in = 1'b0;
      if (step_go) begin
         state_in    = state_step;
         out_vld_in  = 1'b1;
         out_data_in = {state_step.paired, state_step.believes_recording,
                        cwrc_pkg::mode_code(state_step.mode), step_action};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff                  <= 1'b0;
         out_vld_ff                 <= 1'b0;
         state_ff                   <= cwrc_pkg::state_cleared();
         cfg_ff.serial_present_init <= 1'b0;
         cfg_ff.rpm_on_level        <= 16'd1000;
         cfg_ff.rpm_off_level       <= 16'd500;
         cfg_ff.rpm_on_hold_ms      <= 32'd2000;
         cfg_ff.record_start_ms     <= 32'd5000;
         cfg_ff.stop_record_ms      <= 32'd30000;
         cfg_ff.connect_window_ms   <= 32'd10000;
         cfg_ff.subscribe_window_ms <= 32'd5000;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         state_ff   <= state_in;
         cfg_ff     <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   a_step_fills_out: assert property (@(posedge clock) disable iff (reset)
      step_go |=> out_vld_ff)
      else $error("step committed but no result word held");

   a_wake_tries_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.wake_tries <= cwrc_pkg::TRIES_W'(WAKE_RETRIES))
      else $error("wake retry count above limit");

   a_waking_has_try: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == cwrc_pkg::MODE_WAKING |-> state_ff.wake_tries != '0)
      else $error("waking without a wake attempt counted");

   a_out_mode_match: assert property (@(posedge clock) disable iff (reset)
      step_go |=> rsp_tdata[5:3] == cwrc_pkg::mode_code(state_ff.mode))
      else $error("reported mode differs from held mode");

endmodule

@@ tb/sv/tb_camera_wake_record_controller_unit.sv @@
`timescale 1ns / 100ps

module tb_camera_wake_record_controller_unit;

   localparam logic [1:0] SEEN_UNKNOWN = 2'd0;
   localparam logic [1:0] SEEN_ODD     = 2'd3;

   // result word, laid out exactly as rsp_tdata
   typedef struct packed {
      logic       paired_flag;
      logic       recording_belief;
      logic [2:0] mode_now;
      logic [2:0] action;
   } status_word_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [cwrc_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                             req_tuser = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [cwrc_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             csr_we = 1'b0;
   logic [cwrc_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [cwrc_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   camera_wake_record_controller_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("tb_camera_wake_record_controller_unit: errors");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // controller mirror: settings, state, timers
   // ---------------------------------------------------------------------------
   cwrc_pkg::cfg_type cfg_shadow;
   logic [2:0]   st_mode, st_return;
   logic         st_paired, st_belief, st_retry_spent, st_entry_owed;
   logic [31:0]  t_rpm_on, t_rpm_gone, t_attempt, t_connect;
   logic [31:0]  t_arm, t_stop, t_idle_seen, t_pair;
   logic [3:0]   n_wake, n_sub;

   status_word_type status_owed[$];
   int           err_count = 0;
   bit           gaps_on = 1'b1;
   int           rsp_hold_cycles = 0;

   // stimulus world: time base, engine and link behavior
   logic [31:0]  w_now = 32'd0;
   bit           w_engine = 1'b0;
   bit           w_link = 1'b0;
   bit           w_sub = 1'b0;

   function automatic logic [31:0] stamp_of(input logic [31:0] t_now);
      return (t_now == 32'd0) ? 32'd1 : t_now;
   endfunction

   function automatic bit elapsed(input logic [31:0] t_now, since, span);
      logic [31:0] d;
      d = t_now - since;
      return d >= span;
   endfunction

   function automatic void clear_timers();
      t_rpm_on = '0; t_rpm_gone = '0; t_attempt = '0; t_connect = '0;
      t_arm = '0; t_stop = '0; t_idle_seen = '0; t_pair = '0;
      n_wake = '0; n_sub = '0;
      st_retry_spent = 1'b0; st_entry_owed = 1'b0;
   endfunction

   function automatic void clear_state();
      clear_timers();
      st_mode   = cwrc_pkg::CODE_UNPAIRED;
      st_return = cwrc_pkg::CODE_UNPAIRED;
      st_paired = 1'b0;
      st_belief = 1'b0;
   endfunction

   function automatic void track_arm(input logic [31:0] t_now, input logic [15:0] rpm);
      if (rpm > cfg_shadow.rpm_on_level) begin
         if (t_arm == '0) t_arm = stamp_of(t_now);
      end else if (rpm < cfg_shadow.rpm_off_level) begin
         t_arm = '0;
      end
   endfunction

   function automatic void go_idle(input bit keep_belief);
      clear_timers();
      if (!keep_belief) st_belief = 1'b0;
      st_mode = cwrc_pkg::CODE_IDLE;
   endfunction

   function automatic void go_await(input logic [31:0] t_now);
      st_mode = cwrc_pkg::CODE_AWAIT;
      t_connect = stamp_of(t_now);
      st_entry_owed = 1'b0;
   endfunction

   function automatic logic [2:0] go_watch(input logic [2:0] act, input bit reset_arm);
      st_mode = cwrc_pkg::CODE_WATCHING;
      if (reset_arm) t_arm = '0;
      t_stop = '0;
      return act;
   endfunction

   function automatic logic [2:0] go_wake(input logic [31:0] t_now);
      st_mode = cwrc_pkg::CODE_WAKING;
      n_wake = 4'd1;
      t_attempt = stamp_of(t_now);
      t_rpm_gone = '0;
      return cwrc_pkg::ACT_WAKE;
   endfunction

   function automatic logic [2:0] go_record(input bit shutter);
      st_mode = cwrc_pkg::CODE_RECORDING;
      t_stop = '0; t_idle_seen = '0;
      st_retry_spent = 1'b0; n_sub = '0;
      st_belief = 1'b1;
      return shutter ? cwrc_pkg::ACT_SHUTTER : cwrc_pkg::ACT_NONE;
   endfunction

   function automatic logic [2:0] stop_and_watch();
      if (st_belief) begin
         st_belief = 1'b0;
         return go_watch(cwrc_pkg::ACT_SHUTTER, 1'b1);
      end
      return go_watch(cwrc_pkg::ACT_NONE, 1'b1);
   endfunction

   // one step of the controller: updates the mirror, returns the status word
   function automatic status_word_type controller_step(input cwrc_pkg::item_type it);
      status_word_type w;
      logic [2:0]   act;
      logic [2:0]   prev;
      logic [31:0]  t_now;
      bit           gone_abort;
      bit           resent;
      act   = cwrc_pkg::ACT_NONE;
      t_now = it.now_ms;
      if (it.req_type == cwrc_pkg::REQ_INIT) begin
         clear_state();
         st_paired = cfg_shadow.serial_present_init;
         st_mode = st_paired ? cwrc_pkg::CODE_IDLE : cwrc_pkg::CODE_UNPAIRED;
      end else if (it.force_idle) begin
         prev = st_mode;
         clear_timers();
         st_belief = 1'b0;
         st_mode = st_paired ? cwrc_pkg::CODE_IDLE : cwrc_pkg::CODE_UNPAIRED;
         if (prev == cwrc_pkg::CODE_WAKING || prev == cwrc_pkg::CODE_PAIRING)
            act = cwrc_pkg::ACT_STOP_ADV;
      end else if (it.unpair_req && (st_mode == cwrc_pkg::CODE_UNPAIRED ||
                                     st_mode == cwrc_pkg::CODE_IDLE)) begin
         st_mode = cwrc_pkg::CODE_UNPAIRED;
         st_paired = 1'b0;
         act = cwrc_pkg::ACT_DISC;
      end else begin
         // pairing entry falls through so connectable advertising goes out now
         if (it.pair_req && (st_mode == cwrc_pkg::CODE_UNPAIRED ||
                             st_mode == cwrc_pkg::CODE_IDLE)) begin
            st_return = st_mode;
            st_mode = cwrc_pkg::CODE_PAIRING;
            t_pair = stamp_of(t_now);
            st_entry_owed = 1'b1;
         end
         if (it.serial_captured) st_paired = 1'b1;
         if (it.serial_captured && st_mode == cwrc_pkg::CODE_PAIRING) begin
            go_idle(1'b0);
            act = cwrc_pkg::ACT_DISC;
         end else begin
            case (st_mode)
               cwrc_pkg::CODE_IDLE: begin
                  if (it.rpm <= cfg_shadow.rpm_on_level) begin
                     t_rpm_on = '0;
                  end else if (t_rpm_on == '0) begin
                     t_rpm_on = stamp_of(t_now);
                  end else if (elapsed(t_now, t_rpm_on, cfg_shadow.rpm_on_hold_ms)) begin
                     t_rpm_on = '0;
                     t_arm = stamp_of(t_now);
                     if (it.link_up) go_await(t_now);
                     else act = go_wake(t_now);
                  end
               end
               cwrc_pkg::CODE_WAKING: begin
                  if (it.link_up) begin
                     go_await(t_now);
                  end else begin
                     track_arm(t_now, it.rpm);
                     gone_abort = 1'b0;
                     if (it.rpm < cfg_shadow.rpm_off_level) begin
                        if (t_rpm_gone == '0) t_rpm_gone = stamp_of(t_now);
                        else if (elapsed(t_now, t_rpm_gone,
                                         cwrc_pkg::RPM_GONE_ABORT_MS_DEF))
                           gone_abort = 1'b1;
                     end else begin
                        t_rpm_gone = '0;
                     end
                     if (gone_abort) begin
                        go_idle(1'b1);
                        act = cwrc_pkg::ACT_STOP_ADV;
                     end else if (elapsed(t_now, t_attempt, cfg_shadow.connect_window_ms)) begin
                        if (n_wake < cwrc_pkg::WAKE_RETRIES_DEF) begin
                           n_wake = n_wake + 4'd1;
                           t_attempt = stamp_of(t_now);
                           t_rpm_gone = '0;
                           act = cwrc_pkg::ACT_WAKE;
                        end else begin
                           go_idle(1'b1);
                           act = cwrc_pkg::ACT_STOP_ADV;
                        end
                     end else if (it.session_end) begin
                        go_idle(1'b1);
                        act = cwrc_pkg::ACT_STOP_ADV;
                     end
                  end
               end
               cwrc_pkg::CODE_AWAIT: begin
                  track_arm(t_now, it.rpm);
                  if (!it.link_up) begin
                     act = go_wake(t_now);
                  end else if (it.session_end) begin
                     if (st_belief && it.camera_subscribed) begin
                        st_belief = 1'b0;
                        act = go_watch(cwrc_pkg::ACT_SHUTTER, 1'b1);
                     end else begin
                        act = go_watch(cwrc_pkg::ACT_NONE, 1'b1);
                     end
                  end else if (!it.camera_subscribed &&
                               elapsed(t_now, t_connect, cfg_shadow.subscribe_window_ms)) begin
                     n_sub = n_sub + 4'd1;
                     if (n_sub > cwrc_pkg::SUBSCRIBE_RETRIES_DEF) go_idle(1'b1);
                     else void'(go_wake(t_now));
                     act = cwrc_pkg::ACT_DISC;
                  end else if (it.camera_subscribed) begin
                     n_sub = '0;
                     act = go_watch(cwrc_pkg::ACT_NONE, 1'b0);
                  end
               end
               cwrc_pkg::CODE_RECORDING: begin
                  if (it.session_end) begin
                     act = stop_and_watch();
                  end else if (!it.link_up) begin
                     act = go_wake(t_now);
                  end else begin
                     resent = 1'b0;
                     if (it.record_seen == cwrc_pkg::SEEN_RECORDING) begin
                        t_idle_seen = '0;
                        st_retry_spent = 1'b0;
                     end else if (it.record_seen == cwrc_pkg::SEEN_IDLE && st_belief) begin
                        // camera looks idle while we think it records: one retry
                        if (!st_retry_spent) begin
                           if (t_idle_seen == '0) begin
                              t_idle_seen = stamp_of(t_now);
                           end else if (elapsed(t_now, t_idle_seen,
                                                cwrc_pkg::RECORD_CONFIRM_MS_DEF)) begin
                              t_idle_seen = '0;
                              st_retry_spent = 1'b1;
                              act = cwrc_pkg::ACT_SHUTTER;
                              resent = 1'b1;
                           end
                        end
                     end else begin
                        t_idle_seen = '0;
                     end
                     if (!resent) begin
                        if (it.rpm < cfg_shadow.rpm_off_level) begin
                           if (t_stop == '0) begin
                              t_stop = stamp_of(t_now);
                           end else if (elapsed(t_now, t_stop, cfg_shadow.stop_record_ms)) begin
                              t_stop = '0;
                              act = stop_and_watch();
                           end
                        end else begin
                           t_stop = '0;
                        end
                     end
                  end
               end
               cwrc_pkg::CODE_WATCHING: begin
                  track_arm(t_now, it.rpm);
                  if (!it.link_up) begin
                     go_idle(1'b0);
                  end else if (!it.session_end && it.camera_subscribed && t_arm != '0 &&
                               elapsed(t_now, t_arm, cfg_shadow.record_start_ms)) begin
                     if (it.record_seen == cwrc_pkg::SEEN_RECORDING) act = go_record(1'b0);
                     else if (it.record_seen == cwrc_pkg::SEEN_IDLE) act = go_record(1'b1);
                     else act = go_record(!st_belief);
                  end
               end
               cwrc_pkg::CODE_PAIRING: begin
                  if (st_entry_owed) begin
                     st_entry_owed = 1'b0;
                     act = cwrc_pkg::ACT_CONN_ADV;
                  end else if (it.pair_cancel ||
                               elapsed(t_now, t_pair, cwrc_pkg::PAIRING_TIMEOUT_MS_DEF)) begin
                     st_mode = st_return;
                     t_rpm_on = '0;
                     act = cwrc_pkg::ACT_STOP_ADV;
                  end
               end
               default: act = cwrc_pkg::ACT_NONE;
            endcase
         end
      end
      w.action           = act;
      w.mode_now         = st_mode;
      w.recording_belief = st_belief;
      w.paired_flag      = st_paired;
      return w;
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------
   function automatic int draw_gap();
      if (!gaps_on || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, 17);
   endfunction

   function automatic cwrc_pkg::item_type step_at(input logic [31:0] t_now,
                                                  input logic [15:0] rpm,
                                                  input logic link, sub,
                                                  input logic [1:0] seen);
      cwrc_pkg::item_type it;
      it = '0;
      it.req_type          = cwrc_pkg::REQ_STEP;
      it.now_ms            = t_now;
      it.rpm               = rpm;
      it.link_up           = link;
      it.camera_subscribed = sub;
      it.record_seen       = seen;
      return it;
   endfunction

   // mostly plausible drives: time creeps forward, engine and link persist
   function automatic cwrc_pkg::item_type next_world_item();
      cwrc_pkg::item_type it;
      int unsigned roll;
      it = '0;
      roll = $urandom_range(0, 99);
      if (roll < 85) w_now = w_now + $urandom_range(0, 400);
      else if (roll < 97) w_now = w_now + $urandom_range(1000, 70000);
      else w_now = $urandom();
      it.now_ms = w_now;

      if ($urandom_range(0, 99) < 6) w_engine = !w_engine;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         it.rpm = 16'($urandom_range(0, 65535));
      else if (w_engine)
         it.rpm = (cfg_shadow.rpm_on_level == 16'hFFFF) ? 16'hFFFF :
                  16'($urandom_range(cfg_shadow.rpm_on_level + 1, 65535));
      else
         it.rpm = (cfg_shadow.rpm_off_level == 16'h0000) ? 16'h0000 :
                  16'($urandom_range(0, cfg_shadow.rpm_off_level - 1));

      if ($urandom_range(0, 99) < (w_link ? 4 : 25)) w_link = !w_link;
      if (!w_link) w_sub = 1'b0;
      else if (!w_sub && $urandom_range(0, 99) < 30) w_sub = 1'b1;
      else if (w_sub && $urandom_range(0, 99) < 3) w_sub = 1'b0;
      it.link_up = w_link;
      it.camera_subscribed = ($urandom_range(0, 99) < 4) ? !w_sub : w_sub;

      if (st_belief && $urandom_range(0, 99) < 70) it.record_seen = cwrc_pkg::SEEN_RECORDING;
      else it.record_seen = 2'($urandom_range(0, 3));

      it.session_end = $urandom_range(0, 99) < 3;
      it.force_idle  = $urandom_range(0, 99) < 2;
      it.unpair_req  = $urandom_range(0, 99) < 2;
      it.pair_req    = $urandom_range(0, 99) < ((st_mode == cwrc_pkg::CODE_UNPAIRED) ? 12 : 3);
      it.serial_captured =
         $urandom_range(0, 99) < ((st_mode == cwrc_pkg::CODE_PAIRING) ? 25 : 2);
      it.pair_cancel =
         $urandom_range(0, 99) < ((st_mode == cwrc_pkg::CODE_PAIRING) ? 10 : 2);
      it.req_type    = ($urandom_range(0, 99) < 1) ? cwrc_pkg::REQ_INIT : cwrc_pkg::REQ_STEP;
      return it;
   endfunction

   // offer one word, predict its status once it is taken
   task automatic send_word(input cwrc_pkg::item_type it);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.req_type;
      req_tdata  <= {6'b0, it.pair_cancel, it.serial_captured, it.pair_req, it.unpair_req,
                     it.force_idle, it.session_end, it.record_seen, it.camera_subscribed,
                     it.link_up, it.rpm, it.now_ms};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      status_owed.push_back(controller_step(it));
   endtask

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
         send_word(next_world_item());
      end
   endtask

   // stop offering and wait until every status word is back
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (status_owed.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [cwrc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         cwrc_pkg::CSR_SERIAL_PRESENT_INIT: cfg_shadow.serial_present_init = val[0];
         cwrc_pkg::CSR_RPM_ON_LEVEL:        cfg_shadow.rpm_on_level        = val[15:0];
         cwrc_pkg::CSR_RPM_OFF_LEVEL:       cfg_shadow.rpm_off_level       = val[15:0];
         cwrc_pkg::CSR_RPM_ON_HOLD_MS:      cfg_shadow.rpm_on_hold_ms      = val;
         cwrc_pkg::CSR_RECORD_START_MS:     cfg_shadow.record_start_ms     = val;
         cwrc_pkg::CSR_STOP_RECORD_MS:      cfg_shadow.stop_record_ms      = val;
         cwrc_pkg::CSR_CONNECT_WINDOW_MS:   cfg_shadow.connect_window_ms   = val;
         cwrc_pkg::CSR_SUBSCRIBE_WINDOW_MS: cfg_shadow.subscribe_window_ms = val;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic serial, input logic [15:0] on_lvl, off_lvl,
                                 input logic [31:0] hold, rec_start, stop_ms, conn_win,
                                 sub_win);
      cwrc_pkg::item_type it;
      settle();
      write_csr(cwrc_pkg::CSR_SERIAL_PRESENT_INIT, {31'b0, serial});
      write_csr(cwrc_pkg::CSR_RPM_ON_LEVEL, {16'b0, on_lvl});
      write_csr(cwrc_pkg::CSR_RPM_OFF_LEVEL, {16'b0, off_lvl});
      write_csr(cwrc_pkg::CSR_RPM_ON_HOLD_MS, hold);
      write_csr(cwrc_pkg::CSR_RECORD_START_MS, rec_start);
      write_csr(cwrc_pkg::CSR_STOP_RECORD_MS, stop_ms);
      write_csr(cwrc_pkg::CSR_CONNECT_WINDOW_MS, conn_win);
      write_csr(cwrc_pkg::CSR_SUBSCRIBE_WINDOW_MS, sub_win);
      // re-init so the stored serial setting takes effect
      it = step_at(w_now, 16'd0, 1'b0, 1'b0, SEEN_UNKNOWN);
      it.req_type = cwrc_pkg::REQ_INIT;
      send_word(it);
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------
   task automatic test_directed();
      cwrc_pkg::item_type it;
      gaps_on = 1'b1;
      // init ignores every other field
      it = step_at(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, SEEN_ODD);
      it.req_type = cwrc_pkg::REQ_INIT;
      it.session_end = 1'b1; it.force_idle = 1'b1; it.unpair_req = 1'b1;
      it.pair_req = 1'b1; it.serial_captured = 1'b1; it.pair_cancel = 1'b1;
      send_word(it);
      // pairing entry at time zero, then timeout back to unpaired
      it = step_at(32'd0, 16'd0, 1'b0, 1'b0, SEEN_UNKNOWN);
      it.pair_req = 1'b1;
      send_word(it);
      send_word(step_at(32'd30000, 16'd0, 1'b0, 1'b0, SEEN_UNKNOWN));
      send_word(step_at(32'd60001, 16'd0, 1'b0, 1'b0, SEEN_UNKNOWN));
      // pairing cancelled
      it = step_at(32'd61000, 16'd0, 1'b0, 1'b0, SEEN_UNKNOWN);
      it.pair_req = 1'b1;
      send_word(it);
      it = step_at(32'd61010, 16'd0, 1'b0, 1'b0, SEEN_UNKNOWN);
      it.pair_cancel = 1'b1;
      send_word(it);
      // pair request and serial capture in one word
      it = step_at(32'd62000, 16'd0, 1'b0, 1'b0, SEEN_UNKNOWN);
      it.pair_req = 1'b1; it.serial_captured = 1'b1;
      send_word(it);
      it = step_at(32'd62010, 16'd0, 1'b0, 1'b0, SEEN_UNKNOWN);
      it.unpair_req = 1'b1;
      send_word(it);
      // capture outside pairing only sets the paired flag
      it = step_at(32'd62020, 16'd0, 1'b0, 1'b0, SEEN_UNKNOWN);
      it.serial_captured = 1'b1;
      send_word(it);
      it = step_at(32'd62030, 16'd0, 1'b0, 1'b0, SEEN_UNKNOWN);
      it.force_idle = 1'b1;
      send_word(it);
      // engine on across the zero stamp, wake, then forced idle while waking
      send_word(step_at(32'd0, 16'hFFFF, 1'b0, 1'b0, SEEN_UNKNOWN));
      send_word(step_at(32'd2001, 16'd2000, 1'b0, 1'b0, SEEN_UNKNOWN));
      it = step_at(32'd2010, 16'd2000, 1'b0, 1'b0, SEEN_UNKNOWN);
      it.force_idle = 1'b1;
      send_word(it);
      // link already up: straight to await, watch, record
      send_word(step_at(32'd3000, 16'd2000, 1'b0, 1'b0, SEEN_UNKNOWN));
      send_word(step_at(32'd5000, 16'd2000, 1'b1, 1'b0, SEEN_UNKNOWN));
      send_word(step_at(32'd5100, 16'd2000, 1'b1, 1'b1, SEEN_UNKNOWN));
      send_word(step_at(32'd10000, 16'd2000, 1'b1, 1'b1, SEEN_ODD));
      // camera reports idle while recording: one shutter retry
      send_word(step_at(32'd10100, 16'd2000, 1'b1, 1'b1, cwrc_pkg::SEEN_IDLE));
      send_word(step_at(32'd12100, 16'd2000, 1'b1, 1'b1, cwrc_pkg::SEEN_IDLE));
      // engine off long enough stops recording
      send_word(step_at(32'd12200, 16'd0, 1'b1, 1'b1, cwrc_pkg::SEEN_RECORDING));
      send_word(step_at(32'd42200, 16'd0, 1'b1, 1'b1, cwrc_pkg::SEEN_RECORDING));
      send_word(step_at(32'd42300, 16'd0, 1'b0, 1'b0, cwrc_pkg::SEEN_IDLE));
      it = step_at(32'hFFFF_FFFF, 16'd0, 1'b0, 1'b0, SEEN_UNKNOWN);
      it.session_end = 1'b1;
      send_word(it);
      w_now = 32'd42400;
   endtask

   task automatic test_config_sweep();
      // everything immediate
      apply_settings(1'b1, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      run_random(60);
      // nothing ever counts as engine on, windows never close
      apply_settings(1'b0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_random(50);
      apply_settings(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom());
      run_random(50);
   endtask

   task automatic test_random_drive();
      apply_settings(1'b1, 16'd1000, 16'd500, 32'd100, 32'd300, 32'd400, 32'd600, 32'd300);
      for (int i = 0; i < 3; i++) begin
         run_random(120);
         if (i == 1) settle();
      end
   endtask

   task automatic test_backpressure();
      gaps_on = 1'b0;
      rsp_hold_cycles = 80;
      for (int i = 0; i < 40; i++) send_word(next_world_item());
      settle();
      gaps_on = 1'b1;
   endtask

   task automatic test_pause_until_drained();
      run_random(20);
      settle();
      run_random(20);
   endtask

   // ---------------------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------------------
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end
         stall = draw_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   status_word_type want_w, got_w;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_w = rsp_tdata;
         if (status_owed.size() == 0) begin
            $error("status word 0x%02h with nothing outstanding", rsp_tdata);
            err_count++;
         end else begin
            want_w = status_owed.pop_front();
            if (got_w.action !== want_w.action) begin
               $error("action: expected %0d, got %0d", want_w.action, got_w.action);
               err_count++;
            end
            if (got_w.mode_now !== want_w.mode_now) begin
               $error("mode_now: expected %0d, got %0d", want_w.mode_now, got_w.mode_now);
               err_count++;
            end
            if (got_w.recording_belief !== want_w.recording_belief) begin
               $error("recording_belief: expected %0d, got %0d",
                      want_w.recording_belief, got_w.recording_belief);
               err_count++;
            end
            if (got_w.paired_flag !== want_w.paired_flag) begin
               $error("paired_flag: expected %0d, got %0d",
                      want_w.paired_flag, got_w.paired_flag);
               err_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------
   initial begin
      cfg_shadow.serial_present_init = 1'b0;
      cfg_shadow.rpm_on_level        = 16'd1000;
      cfg_shadow.rpm_off_level       = 16'd500;
      cfg_shadow.rpm_on_hold_ms      = 32'd2000;
      cfg_shadow.record_start_ms     = 32'd5000;
      cfg_shadow.stop_record_ms      = 32'd30000;
      cfg_shadow.connect_window_ms   = 32'd10000;
      cfg_shadow.subscribe_window_ms = 32'd5000;
      clear_state();
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_config_sweep();
      test_random_drive();
      test_backpressure();
      test_pause_until_drained();
      settle();

      if (err_count == 0) begin
         $display("tb_camera_wake_record_controller_unit: clean");
      end else begin
         $display("tb_camera_wake_record_controller_unit: errors");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/cwrc_pkg.sv
rtl/core/cwrc_step.sv
rtl/core/camera_wake_record_controller_unit.sv
tb/sv/tb_camera_wake_record_controller_unit.sv
